[hdl/quoted_field_tokenizer_macros.svh]
// Assertion macros for the quoted-field tokenizer.
// Expects a clock named clk and an active-high reset named rst in scope.
`ifndef QUOTED_FIELD_TOKENIZER_MACROS_SVH
`define QUOTED_FIELD_TOKENIZER_MACROS_SVH

// Same-cycle implication, off during reset.
`define QFT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tokenizer check failed");

// Next-cycle implication, off during reset.
`define QFT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tokenizer check failed");

`endif

[hdl/qft_pkg.sv]
// Shared types and constants for the quoted-field tokenizer.
// No dependencies; used by qft_decode and quoted_field_tokenizer.
`default_nettype none

package qft_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_BARE    = 3'd1,
    MODE_QUOTED  = 3'd2,
    MODE_ESCAPE  = 3'd3,
    MODE_DISCARD = 3'd4
  } scan_mode_t;

  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_SPACE     = 8'h20;

  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_BAD_ESCAPE = 2'd1;
  localparam logic [1:0] ERR_ESC_AT_END = 2'd2;
  localparam logic [1:0] ERR_OPEN_QUOTE = 2'd3;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_line;
  } tok_in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       has_char;
    logic       token_end;
    logic       line_done;
    logic [1:0] err_code;
  } tok_out_t;

  function automatic logic is_blank(input logic [7:0] b);
    return ((b >= CH_TAB) && (b <= CH_CR)) || (b == CH_SPACE);
  endfunction

endpackage

`default_nettype wire

[hdl/qft_decode.sv]
// Per-byte decode of the tokenizer: next scan mode and the result, if any.
// Depends on qft_pkg.
`default_nettype none

module qft_decode (
  input  qft_pkg::scan_mode_t mode,
  input  qft_pkg::tok_in_t    item,
  output qft_pkg::scan_mode_t mode_next,
  output logic                emit,
  output qft_pkg::tok_out_t   result
);
  import qft_pkg::*;

  logic       blank;
  logic [7:0] b;

  assign b     = item.byte_value;
  assign blank = is_blank(b);

  // Next state
  always_comb begin
    mode_next = mode;
    if (item.end_of_line) begin
      mode_next = MODE_IDLE;
    end else begin
      unique case (mode)
        MODE_BARE: begin
          if (blank) mode_next = MODE_IDLE;
        end
        MODE_QUOTED: begin
          if (b == CH_QUOTE) mode_next = MODE_IDLE;
          else if (b == CH_BACKSLASH) mode_next = MODE_ESCAPE;
        end
        MODE_ESCAPE: begin
          if ((b == CH_QUOTE) || (b == CH_BACKSLASH) || (b == CH_N)) begin
            mode_next = MODE_QUOTED;
          end else begin
            mode_next = MODE_DISCARD;
          end
        end
        MODE_DISCARD: mode_next = MODE_DISCARD;
        default: begin
          if (blank) mode_next = MODE_IDLE;
          else if (b == CH_QUOTE) mode_next = MODE_QUOTED;
          else mode_next = MODE_BARE;
        end
      endcase
    end
  end

  // Outputs
  always_comb begin
    emit   = 1'b0;
    result = '0;
    if (item.end_of_line) begin
      emit             = 1'b1;
      result.line_done = 1'b1;
      unique case (mode)
        MODE_BARE:   result.token_end = 1'b1;
        MODE_QUOTED: result.err_code  = ERR_OPEN_QUOTE;
        MODE_ESCAPE: result.err_code  = ERR_ESC_AT_END;
        default:     result.err_code  = ERR_NONE;
      endcase
    end else begin
      unique case (mode)
        MODE_BARE: begin
          emit = 1'b1;
          if (blank) begin
            result.token_end = 1'b1;
          end else begin
            result.out_char = b;
            result.has_char = 1'b1;
          end
        end
        MODE_QUOTED: begin
          if (b == CH_QUOTE) begin
            emit             = 1'b1;
            result.token_end = 1'b1;
          end else if (b != CH_BACKSLASH) begin
            emit            = 1'b1;
            result.out_char = b;
            result.has_char = 1'b1;
          end
        end
        MODE_ESCAPE: begin
          emit = 1'b1;
          if ((b == CH_QUOTE) || (b == CH_BACKSLASH)) begin
            result.out_char = b;
            result.has_char = 1'b1;
          end else if (b == CH_N) begin
            result.out_char = CH_NEWLINE;
            result.has_char = 1'b1;
          end else begin
            result.err_code = ERR_BAD_ESCAPE;
          end
        end
        MODE_DISCARD: emit = 1'b0;
        default: begin
          // Start a bare token on anything but blank or quote
          if (!blank && (b != CH_QUOTE)) begin
            emit            = 1'b1;
            result.out_char = b;
            result.has_char = 1'b1;
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[hdl/quoted_field_tokenizer.sv]
// Quoted-field tokenizer top level: scan mode register, decode, result register.
// Depends on qft_pkg, qft_decode and quoted_field_tokenizer_macros.svh.
//
//   channel | signals                       | payload
//   --------+-------------------------------+-----------------------------
//   input   | in_valid / in_ready           | in_data  (qft_pkg::tok_in_t)
//   output  | out_valid / out_ready         | out_data (qft_pkg::tok_out_t)
//
// One byte or end-of-line marker per cycle unless the output stalls; a result
// is registered and appears in the cycle after its transfer. The 3-bit scan
// mode register is the only loop. Synchronous reset puts the scanner between
// tokens and empties the result register. Input is taken whenever the result
// register is empty or being drained in the same cycle.
`default_nettype none

module quoted_field_tokenizer (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  qft_pkg::tok_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output qft_pkg::tok_out_t out_data
);
  import qft_pkg::*;

  `include "quoted_field_tokenizer_macros.svh"

  scan_mode_t mode;
  scan_mode_t mode_next;
  logic       emit;
  tok_out_t   result;
  logic       in_xfer;

  assign in_ready = !out_valid || out_ready;
  assign in_xfer  = in_valid && in_ready;

  qft_decode u_decode (
    .mode      (mode),
    .item      (in_data),
    .mode_next (mode_next),
    .emit      (emit),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (in_xfer) mode <= mode_next;
      if (in_xfer && emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && emit) out_data <= result;
  end

  `QFT_ASSERT_NEXT(a_eol_returns_idle, in_xfer && in_data.end_of_line, mode == MODE_IDLE)
  `QFT_ASSERT_NOW(a_discard_from_escape, mode == MODE_DISCARD, ($past(mode) == MODE_DISCARD) || ($past(mode) == MODE_ESCAPE))
  `QFT_ASSERT_NOW(a_error_no_char, out_valid && (out_data.err_code != ERR_NONE), !out_data.has_char && !out_data.token_end)
  `QFT_ASSERT_NOW(a_done_no_char, out_valid && out_data.line_done, !out_data.has_char)

endmodule

`default_nettype wire
